>>> src/four_level_page_table_walker_assert.svh
// Assertion macros for the four-level page table walker.
// Used by four_level_page_table_walker.sv; expects clk and rst_n in scope.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLPTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/flptw_pkg.sv
// Package for the four-level page table walker: codes, result record type
// and the entry address helper. No dependencies.
package flptw_pkg;

  localparam int PA_W            = 52;
  localparam int PHYS_ADDR_BITS_D = 52;
  localparam int LEVELS          = 4;
  localparam int OUT_DEPTH       = 4;
  localparam int OUT_PTR_W       = $clog2(OUT_DEPTH);

  // command carried in in_tuser
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_ENTRY     = 1'b1;

  // access kinds; the unused code behaves as a read
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_MEM_READ  = 3'd0;
  localparam logic [2:0] KIND_MEM_WRITE = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_FAULT     = 3'd3;
  localparam logic [2:0] KIND_NONCANON  = 3'd4;

  // fault reasons
  localparam logic [2:0] RSN_NOT_PRESENT = 3'd0;
  localparam logic [2:0] RSN_USER        = 3'd1;
  localparam logic [2:0] RSN_WP          = 3'd2;
  localparam logic [2:0] RSN_XD          = 3'd3;
  localparam logic [2:0] RSN_RSVD        = 3'd4;

  // page size codes
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CR3 = 2'd0;
  localparam logic [1:0] REG_WP  = 2'd1;
  localparam logic [1:0] REG_NX  = 2'd2;

  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [PA_W-1:0] mem_address;
    logic [63:0]     mem_write_data;
    logic [63:0]     virt_page;
    logic [PA_W-1:0] frame_base;
    logic [1:0]      page_size_code;
    logic [2:0]      permissions;
    logic            dirty;
    logic [2:0]      fault_reason;
    logic [4:0]      error_code;
    logic            last;
  } result_t;

  // Table base with the 9-bit index of this level placed at bits 11:3.
  function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] tbl,
                                                 input level_t lvl,
                                                 input logic [63:0] lin);
    logic [8:0] idx;
    case (lvl)
      LVL_PML4: idx = lin[47:39];
      LVL_PDPT: idx = lin[38:30];
      LVL_PD:   idx = lin[29:21];
      default:  idx = lin[20:12];
    endcase
    return {tbl[PA_W-1:12], idx, 3'b000};
  endfunction

  // Offset mask of a page of the given size.
  function automatic logic [63:0] page_mask(input logic [1:0] size);
    case (size)
      SIZE_1G: return 64'h0000_0000_3FFF_FFFF;
      SIZE_2M: return 64'h0000_0000_001F_FFFF;
      default: return 64'h0000_0000_0000_0FFF;
    endcase
  endfunction

endpackage

>>> src/four_level_page_table_walker.sv
// A result passes through the input register and then the result queue before it is offered;
// a second result of the same transaction enters the queue with the first and follows it.
// Throughput: one input transaction per cycle while the result queue has room for its results,
// set by the single-pass check logic and a four-entry queue; each result takes one queue slot.
// Reset (rst_n low, synchronous): idle, level PML4, result queue and config registers cleared.
module four_level_page_table_walker
  import flptw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_D
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: lin_addr[63:0], acc_kind[65:64], user_mode[66],
  //           read_data[130:67], zero fill
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,
  // in_tuser: cmd[0]
  input  logic         in_tuser,
  // out_tdata: mem_address[51:0], mem_write_data[115:52], virt_page[179:116],
  //            frame_base[231:180], page_size_code[233:232], permissions[236:234],
  //            dirty[237], fault_reason[240:238], error_code[245:241], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [247:0] out_tdata,
  // out_tuser: result_kind[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [PA_W-1:0] ADDR_MASK = PA_W'((65'd1 << PHYS_ADDR_BITS) - 65'd1);

  // configuration
  logic [PA_W-1:0] cr3_r;
  logic            wp_r;
  logic            nx_r;
  logic [1:0]      reg_idx;
  logic            cfg_wr;

  // input register
  logic        in_v_r;
  logic        in_cmd_r;
  logic [63:0] in_lin_r;
  logic [1:0]  in_acc_r;
  logic        in_usr_r;
  logic [63:0] in_rd_r;

  // walk state
  logic            busy_r, busy_nxt;
  level_t          lvl_r, lvl_nxt;
  logic [63:0]     lin_r, lin_nxt;
  logic [1:0]      acc_r, acc_nxt;
  logic            usr_r, usr_nxt;
  logic [2:0]      perms_r, perms_nxt;
  logic [PA_W-1:0] pend_r, pend_nxt;

  // result queue
  result_t             fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wp_ptr_r, rp_ptr_r;
  logic [OUT_PTR_W:0]   cnt_r;
  logic                 pop;

  // processing
  logic       proc_go;
  logic [1:0] n_res;
  result_t    res0, res1;

  logic            canon;
  logic            huge, leaf;
  logic            f_np, f_rsvd, f_user, f_wp, f_xd, any_fault;
  logic [2:0]      reason;
  logic [2:0]      ent_perms, acc_perms;
  logic            is_wr, is_fetch;
  logic [63:0]     upd;
  logic [1:0]      size;
  logic [63:0]     low_mask;
  level_t          lvl_inc;

  // assertion terms
  logic            walk_end;
  logic            rd_issue;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr3_r <= '0;
      wp_r  <= 1'b0;
      nx_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CR3: cr3_r <= cfg_pwdata[PA_W-1:0];
        REG_WP:  wp_r  <= cfg_pwdata[0];
        REG_NX:  nx_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CR3: cfg_prdata = {{(64-PA_W){1'b0}}, cr3_r};
      REG_WP:  cfg_prdata = {63'b0, wp_r};
      REG_NX:  cfg_prdata = {63'b0, nx_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  // queue has room for this transaction's results whenever cnt_r + n_res fits
  assign proc_go   = in_v_r && (({1'b0, cnt_r} + {{(OUT_PTR_W){1'b0}}, n_res})
                                <= (OUT_PTR_W+2)'(OUT_DEPTH));
  assign in_tready = !in_v_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= in_tuser;
      in_lin_r <= in_tdata[63:0];
      in_acc_r <= in_tdata[65:64];
      in_usr_r <= in_tdata[66];
      in_rd_r  <= in_tdata[130:67];
    end
  end

  // ------------------------------------------------------------ entry checks
  assign canon     = (&in_lin_r[63:47]) || !(|in_lin_r[63:47]);
  assign huge      = in_rd_r[7];
  assign leaf      = (lvl_r == LVL_PT) ||
                     (((lvl_r == LVL_PDPT) || (lvl_r == LVL_PD)) && huge);
  assign is_wr     = (acc_r == ACC_WRITE);
  assign is_fetch  = (acc_r == ACC_FETCH);
  assign ent_perms = {!in_rd_r[63], in_rd_r[2], in_rd_r[1]};
  assign acc_perms = perms_r & ent_perms;

  assign f_np   = !in_rd_r[0];
  assign f_rsvd = (|(in_rd_r[PA_W-1:0] & ~ADDR_MASK)) ||
                  (!nx_r && in_rd_r[63]) ||
                  ((lvl_r == LVL_PML4) && huge) ||
                  (leaf && (lvl_r == LVL_PDPT) && (|in_rd_r[29:13])) ||
                  (leaf && (lvl_r == LVL_PD) && (|in_rd_r[20:13]));
  assign f_user = leaf && usr_r && !acc_perms[1];
  assign f_wp   = leaf && is_wr && !acc_perms[0] && (usr_r || wp_r);
  assign f_xd   = leaf && is_fetch && !acc_perms[2];
  assign any_fault = f_np || f_rsvd || f_user || f_wp || f_xd;

  always_comb begin
    if (f_np)        reason = RSN_NOT_PRESENT;
    else if (f_rsvd) reason = RSN_RSVD;
    else if (f_user) reason = RSN_USER;
    else if (f_wp)   reason = RSN_WP;
    else             reason = RSN_XD;
  end

  // set accessed, and dirty on a write to a leaf
  assign upd = in_rd_r | 64'h20 | ((leaf && is_wr) ? 64'h40 : 64'h0);

  always_comb begin
    if (leaf && (lvl_r == LVL_PDPT))    size = SIZE_1G;
    else if (leaf && (lvl_r == LVL_PD)) size = SIZE_2M;
    else                                size = SIZE_4K;
  end
  assign low_mask = page_mask(size);
  assign lvl_inc  = level_t'(lvl_r + 2'd1);

  // ------------------------------------------------------------- decision
  always_comb begin
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;
    busy_nxt  = busy_r;
    lvl_nxt   = lvl_r;
    lin_nxt   = lin_r;
    acc_nxt   = acc_r;
    usr_nxt   = usr_r;
    perms_nxt = perms_r;
    pend_nxt  = pend_r;
    if (in_cmd_r == CMD_TRANSLATE) begin
      if (!busy_r) begin
        n_res     = 2'd1;
        res0.last = 1'b1;
        if (!canon) begin
          res0.kind = KIND_NONCANON;
        end else begin
          lin_nxt          = in_lin_r;
          acc_nxt          = in_acc_r;
          usr_nxt          = in_usr_r;
          perms_nxt        = 3'b111;
          lvl_nxt          = LVL_PML4;
          busy_nxt         = 1'b1;
          pend_nxt         = entry_addr(cr3_r & ADDR_MASK, LVL_PML4, in_lin_r) & ADDR_MASK;
          res0.kind        = KIND_MEM_READ;
          res0.mem_address = pend_nxt;
        end
      end
    end else if (busy_r) begin
      if (any_fault) begin
        n_res             = 2'd1;
        busy_nxt          = 1'b0;
        res0.kind         = KIND_FAULT;
        res0.fault_reason = reason;
        res0.error_code   = {is_fetch && nx_r, reason == RSN_RSVD, usr_r, is_wr,
                             reason != RSN_NOT_PRESENT};
        res0.last         = 1'b1;
      end else begin
        perms_nxt = acc_perms;
        // final result goes in res1; shift it down when no write-back is needed
        if (leaf) begin
          busy_nxt            = 1'b0;
          res1.kind           = KIND_DONE;
          res1.mem_address    = pend_r;
          res1.virt_page      = lin_r & ~low_mask;
          res1.frame_base     = upd[PA_W-1:0] & ADDR_MASK & ~low_mask[PA_W-1:0];
          res1.page_size_code = size;
          res1.permissions    = acc_perms;
          res1.dirty          = upd[6];
          res1.last           = 1'b1;
        end else begin
          lvl_nxt          = lvl_inc;
          pend_nxt         = entry_addr(in_rd_r[PA_W-1:0] & ADDR_MASK, lvl_inc, lin_r)
                             & ADDR_MASK;
          res1.kind        = KIND_MEM_READ;
          res1.mem_address = pend_nxt;
          res1.last        = 1'b1;
        end
        if (upd != in_rd_r) begin
          n_res               = 2'd2;
          res0.kind           = KIND_MEM_WRITE;
          res0.mem_address    = pend_r;
          res0.mem_write_data = upd;
        end else begin
          n_res = 2'd1;
          res0  = res1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      lvl_r  <= LVL_PML4;
    end else if (proc_go) begin
      busy_r <= busy_nxt;
      lvl_r  <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      lin_r   <= lin_nxt;
      acc_r   <= acc_nxt;
      usr_r   <= usr_nxt;
      perms_r <= perms_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // ---------------------------------------------------------- result queue
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (proc_go && (n_res != 2'd0)) begin
      fifo_q[wp_ptr_r] <= res0;
    end
    if (proc_go && (n_res == 2'd2)) begin
      fifo_q[wp_ptr_r + OUT_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_ptr_r <= '0;
      rp_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (proc_go) begin
        wp_ptr_r <= wp_ptr_r + OUT_PTR_W'(n_res);
      end
      if (pop) begin
        rp_ptr_r <= rp_ptr_r + OUT_PTR_W'(1);
      end
      cnt_r <= cnt_r + (proc_go ? (OUT_PTR_W+1)'(n_res) : '0) - (OUT_PTR_W+1)'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = fifo_q[rp_ptr_r].kind;
  assign out_tlast  = fifo_q[rp_ptr_r].last;
  assign out_tdata  = {2'b00,
                       fifo_q[rp_ptr_r].error_code,
                       fifo_q[rp_ptr_r].fault_reason,
                       fifo_q[rp_ptr_r].dirty,
                       fifo_q[rp_ptr_r].permissions,
                       fifo_q[rp_ptr_r].page_size_code,
                       fifo_q[rp_ptr_r].frame_base,
                       fifo_q[rp_ptr_r].virt_page,
                       fifo_q[rp_ptr_r].mem_write_data,
                       fifo_q[rp_ptr_r].mem_address};

  // ------------------------------------------------------------ assertions
  assign walk_end = proc_go && (n_res != 2'd0) && (in_cmd_r == CMD_ENTRY) &&
                    ((res0.kind == KIND_FAULT) || (res1.kind == KIND_DONE));
  assign rd_issue = proc_go && (n_res != 2'd0) && (res0.kind == KIND_MEM_READ);

`include "four_level_page_table_walker_assert.svh"

  `FLPTW_ASSERT_SAME(a_queue_bound, 1'b1, cnt_r <= (OUT_PTR_W+1)'(OUT_DEPTH), "queue overflow")
  `FLPTW_ASSERT_NEXT(a_end_clears_busy, walk_end, !busy_r, "walk end left busy set")
  `FLPTW_ASSERT_NEXT(a_read_sets_busy, rd_issue, busy_r, "entry read issued while idle")

endmodule

>>> dv/tb_four_level_page_table_walker.sv
// Self-checking testbench for the four-level page table walker: directed and random
// walks through the stream ports, register writes through the APB-style port.
// Depends on flptw_pkg and four_level_page_table_walker.
module tb_four_level_page_table_walker;
  import flptw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 310;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [63:0] PA_MASK     = (64'd1 << PHYS_ADDR_BITS_D) - 64'd1;
  localparam logic [63:0] PA_RSVD     = 64'h000F_FFFF_FFFF_FFFF & ~PA_MASK;
  localparam logic [63:0] PTE_P       = 64'h1;
  localparam logic [63:0] PTE_RW      = 64'h2;
  localparam logic [63:0] PTE_US      = 64'h4;
  localparam logic [63:0] PTE_A       = 64'h20;
  localparam logic [63:0] PTE_D       = 64'h40;
  localparam logic [63:0] PTE_PS      = 64'h80;
  localparam logic [63:0] PTE_NX      = 64'h8000_0000_0000_0000;

  typedef struct {
    logic        cmd;
    logic [63:0] lin;
    logic [1:0]  acc;
    logic        usr;
    logic [63:0] data;
  } walk_req_t;

  typedef struct {
    logic            busy;
    level_t          lvl;
    logic [63:0]     lin;
    logic [1:0]      acc;
    logic            usr;
    logic [2:0]      perms;
    logic [PA_W-1:0] tbl;
    logic [PA_W-1:0] pend;
  } walk_state_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata    = '0;
  logic         in_tuser    = 1'b0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [247:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [4:0]   cfg_paddr   = '0;
  logic [63:0]  cfg_pwdata  = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  // register copies seen by the predictor
  logic [PA_W-1:0] cr3_q = '0;
  logic            wp_q  = 1'b0;
  logic            nx_q  = 1'b0;

  walk_state_t walker_st;   // follows accepted transactions
  walk_state_t plan_st;     // follows queued transactions, shapes the stimulus
  walk_req_t   pending_reqs[$];
  walk_req_t   cur_req;
  result_t     expected_results[$];

  int cur_phase     = 0;
  int queued_cnt    = 0;
  int accepted_cnt  = 0;
  int phase_items   = 0;
  int errors        = 0;
  int results_seen  = 0;
  int cycles        = 0;
  int n_done        = 0;
  int n_fault       = 0;
  int n_noncanon    = 0;
  int n_writeback   = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  four_level_page_table_walker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic walk_state_t idle_walk();
    walk_state_t s;
    s.busy  = 1'b0;
    s.lvl   = LVL_PML4;
    s.lin   = '0;
    s.acc   = ACC_READ;
    s.usr   = 1'b0;
    s.perms = 3'b111;
    s.tbl   = '0;
    s.pend  = '0;
    return s;
  endfunction

  function automatic logic [PA_W-1:0] pte_addr(input logic [PA_W-1:0] tbl, input level_t lv,
                                               input logic [63:0] lin);
    logic [63:0] idx;
    logic [63:0] a;
    idx = (lin >> (39 - 9 * int'(lv))) & 64'h1FF;
    a   = ({12'h000, tbl} + (idx << 3)) & PA_MASK;
    return a[PA_W-1:0];
  endfunction

  // Advance the walk by one transaction; returns how many results it causes.
  function automatic int walk_step(inout walk_state_t st, input walk_req_t rq,
                                   output result_t ra, output result_t rb);
    result_t     r[2];
    logic [2:0]  rsn;
    logic [2:0]  pm;
    logic [63:0] upd;
    logic [63:0] low;
    logic [63:0] nxt;
    bit          flt;
    bit          huge;
    bit          leaf;
    int          sh;
    int          n;
    r[0] = '0;
    r[1] = '0;
    ra   = '0;
    rb   = '0;
    n    = 0;
    flt  = 1'b0;
    rsn  = RSN_NOT_PRESENT;
    if (rq.cmd == CMD_TRANSLATE) begin
      if (st.busy) return 0;
      ra.last = 1'b1;
      if (rq.lin[63:47] != 17'h0 && rq.lin[63:47] != 17'h1FFFF) begin
        ra.kind = KIND_NONCANON;
        return 1;
      end
      st.lin   = rq.lin;
      st.acc   = rq.acc;
      st.usr   = rq.usr;
      st.perms = 3'b111;
      st.lvl   = LVL_PML4;
      st.tbl   = {cr3_q[PA_W-1:12], 12'h000} & PA_MASK[PA_W-1:0];
      st.pend  = pte_addr(st.tbl, LVL_PML4, rq.lin);
      st.busy  = 1'b1;
      ra.kind  = KIND_MEM_READ;
      ra.mem_address = st.pend;
      return 1;
    end
    if (!st.busy) return 0;

    huge = rq.data[7];
    leaf = (st.lvl == LVL_PT) || ((st.lvl == LVL_PDPT || st.lvl == LVL_PD) && huge);
    sh   = !leaf || st.lvl == LVL_PT ? 12 : (st.lvl == LVL_PDPT ? 30 : 21);

    if (!rq.data[0]) begin
      flt = 1'b1;
      rsn = RSN_NOT_PRESENT;
    end else if ((rq.data & PA_RSVD) != 0 || (!nx_q && rq.data[63]) ||
                 (st.lvl == LVL_PML4 && huge) ||
                 (sh != 12 && ((rq.data >> 13) & ((64'd1 << (sh - 13)) - 64'd1)) != 0)) begin
      flt = 1'b1;
      rsn = RSN_RSVD;
    end else begin
      pm = {~rq.data[63], rq.data[2], rq.data[1]};
      st.perms &= pm;
      if (leaf) begin
        if (st.usr && !st.perms[1]) begin
          flt = 1'b1;
          rsn = RSN_USER;
        end else if (st.acc == ACC_WRITE && !st.perms[0] && (st.usr || wp_q)) begin
          flt = 1'b1;
          rsn = RSN_WP;
        end else if (st.acc == ACC_FETCH && !st.perms[2]) begin
          flt = 1'b1;
          rsn = RSN_XD;
        end
      end
    end

    if (flt) begin
      ra.kind         = KIND_FAULT;
      ra.fault_reason = rsn;
      ra.error_code   = {st.acc == ACC_FETCH && nx_q, rsn == RSN_RSVD, st.usr,
                         st.acc == ACC_WRITE, rsn != RSN_NOT_PRESENT};
      ra.last         = 1'b1;
      st.busy         = 1'b0;
      return 1;
    end

    upd = rq.data | PTE_A;
    if (leaf && st.acc == ACC_WRITE) upd |= PTE_D;
    if (upd != rq.data) begin
      r[n].kind           = KIND_MEM_WRITE;
      r[n].mem_address    = st.pend;
      r[n].mem_write_data = upd;
      n++;
    end

    if (leaf) begin
      low = (64'd1 << sh) - 64'd1;
      nxt = upd & PA_MASK & ~low;
      r[n].kind           = KIND_DONE;
      r[n].mem_address    = st.pend;
      r[n].virt_page      = st.lin & ~low;
      r[n].frame_base     = nxt[PA_W-1:0];
      r[n].page_size_code = sh == 30 ? SIZE_1G : (sh == 21 ? SIZE_2M : SIZE_4K);
      r[n].permissions    = st.perms;
      r[n].dirty          = upd[6];
      r[n].last           = 1'b1;
      st.busy             = 1'b0;
    end else begin
      nxt    = rq.data & PA_MASK & ~64'hFFF;
      st.tbl = nxt[PA_W-1:0];
      st.lvl = level_t'(st.lvl + 2'd1);
      st.pend = pte_addr(st.tbl, st.lvl, st.lin);
      r[n].kind        = KIND_MEM_READ;
      r[n].mem_address = st.pend;
      r[n].last        = 1'b1;
    end
    n++;
    ra = r[0];
    rb = r[1];
    return n;
  endfunction

  task automatic queue_item(input walk_req_t rq);
    result_t ra;
    result_t rb;
    if (walk_step(plan_st, rq, ra, rb) > 0) phase_items++;
    pending_reqs.push_back(rq);
    queued_cnt++;
  endtask

  task automatic q_tr(input logic [63:0] lin, input logic [1:0] acc, input logic usr);
    walk_req_t rq;
    rq.cmd  = CMD_TRANSLATE;
    rq.lin  = lin;
    rq.acc  = acc;
    rq.usr  = usr;
    rq.data = rand64();
    queue_item(rq);
  endtask

  task automatic q_ent(input logic [63:0] data);
    walk_req_t rq;
    rq.cmd  = CMD_ENTRY;
    rq.lin  = rand64();
    rq.acc  = 2'($urandom_range(3));
    rq.usr  = 1'($urandom_range(1));
    rq.data = data;
    queue_item(rq);
  endtask

  // Mostly well-formed entries, with a few that break one rule.
  function automatic logic [63:0] make_entry(input level_t lv);
    logic [63:0] e;
    e     = rand64();
    e[0]  = $urandom_range(99) < 96;
    e[1]  = $urandom_range(99) < 75;
    e[2]  = $urandom_range(99) < 85;
    e[63] = nx_q ? ($urandom_range(99) < 25) : ($urandom_range(99) < 3);
    case (lv)
      LVL_PML4: e[7] = $urandom_range(99) < 3;
      LVL_PDPT: begin
        e[7] = $urandom_range(99) < 35;
        if (e[7] && $urandom_range(99) < 92) e[29:13] = '0;
      end
      LVL_PD: begin
        e[7] = $urandom_range(99) < 35;
        if (e[7] && $urandom_range(99) < 92) e[20:13] = '0;
      end
      default: ;
    endcase
    return e;
  endfunction

  task automatic queue_walk();
    logic [63:0] tmp;
    logic [63:0] lin;
    // stray entry while idle: must be dropped
    if ($urandom_range(99) < 5) q_ent(rand64());
    tmp = rand64();
    if ($urandom_range(19) == 0) lin = tmp;
    else lin = {{17{tmp[47]}}, tmp[46:0]};
    q_tr(lin, 2'($urandom_range(3)), 1'($urandom_range(1)));
    while (plan_st.busy) begin
      // translate while busy: must be dropped
      if ($urandom_range(99) < 3) q_tr(rand64(), 2'($urandom_range(3)), 1'($urandom_range(1)));
      q_ent(make_entry(plan_st.lvl));
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CR3: cr3_q = val[PA_W-1:0];
      REG_WP:  wp_q  = val[0];
      REG_NX:  nx_q  = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic report(input string msg);
    errors++;
    $display("mismatch %0d: %s", errors, msg);
  endtask

  task automatic chk(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL four_level_page_table_walker");
      $finish;
    end
  end

  // Sender: hold the offered transaction until taken, then predict its results.
  always @(posedge clk) begin : drv
    int      n;
    int      idle_pct;
    result_t ra;
    result_t rb;
    idle_pct = cur_phase < 2 ? 15 : (cur_phase < 4 ? 55 : 0);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        n = walk_step(walker_st, cur_req, ra, rb);
        if (n > 0) expected_results.push_back(ra);
        if (n > 1) expected_results.push_back(rb);
        accepted_cnt++;
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_req   = pending_reqs.pop_front();
        in_tdata  <= {5'd0, cur_req.data, cur_req.usr, cur_req.acc, cur_req.lin};
        in_tuser  <= cur_req.cmd;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin : rcv
    int idle_pct;
    idle_pct = cur_phase < 2 ? 55 : (cur_phase < 4 ? 15 : 0);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (cur_phase == 2 && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= idle_pct;
    end
  end

  always @(posedge clk) begin : mon
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d kind %0d arrived with nothing expected",
                         results_seen, out_tuser));
      end else begin
        want = expected_results.pop_front();
        chk("result_kind", out_tuser, want.kind);
        chk("mem_address", out_tdata[51:0], want.mem_address);
        chk("mem_write_data", out_tdata[115:52], want.mem_write_data);
        chk("virt_page", out_tdata[179:116], want.virt_page);
        chk("frame_base", out_tdata[231:180], want.frame_base);
        chk("page_size_code", out_tdata[233:232], want.page_size_code);
        chk("permissions", out_tdata[236:234], want.permissions);
        chk("dirty", out_tdata[237], want.dirty);
        chk("fault_reason", out_tdata[240:238], want.fault_reason);
        chk("error_code", out_tdata[245:241], want.error_code);
        chk("last", out_tlast, want.last);
        case (want.kind)
          KIND_DONE:      n_done++;
          KIND_FAULT:     n_fault++;
          KIND_NONCANON:  n_noncanon++;
          KIND_MEM_WRITE: n_writeback++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    walker_st = idle_walk();
    plan_st   = idle_walk();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      // ignored transactions may still be in flight
      repeat (6) @(posedge clk);
      case (p)
        0: begin
          cfg_write(REG_CR3, 64'hFFFF_FFFF_FFFF_FFFF);
          cfg_write(REG_WP, 64'h1);
          cfg_write(REG_NX, 64'h1);
        end
        1: begin
          cfg_write(REG_CR3, 64'h0);
          cfg_write(REG_WP, {$urandom, 32'h0});
          cfg_write(REG_NX, 64'h0);
        end
        2: begin
          cfg_write(REG_CR3, rand64());
          cfg_write(REG_WP, 64'h0);
          cfg_write(REG_NX, rand64() | 64'h1);
        end
        3: begin
          cfg_write(REG_CR3, rand64());
          cfg_write(REG_WP, rand64() | 64'h1);
          cfg_write(REG_NX, 64'h0);
        end
        default: begin
          cfg_write(REG_CR3, rand64());
          cfg_write(REG_WP, rand64());
          cfg_write(REG_NX, rand64());
        end
      endcase
      @(posedge clk);
      cur_phase <= p;
      @(negedge clk);
      phase_items = 0;
      if (p == 0) begin
        q_tr(64'h0000_8000_0000_0000, ACC_READ, 1'b0);            // just past canonical
        q_ent(64'h0);                                              // entry while idle
        q_tr(64'h0000_7FFF_FFFF_FFFF, ACC_WRITE, 1'b1);
        q_tr(64'h0, ACC_READ, 1'b0);                               // translate while busy
        q_ent(64'h0000_0000_1234_5000 | PTE_P | PTE_RW | PTE_US);
        q_ent(64'h0000_0000_2345_6000 | PTE_P | PTE_RW | PTE_US | PTE_A);
        q_ent(64'h000F_FFFF_FFFF_F000 | PTE_P | PTE_RW | PTE_US);
        q_ent(64'h0000_0000_0ABC_D000 | PTE_P | PTE_RW | PTE_US);  // 4K leaf, sets A and D
        // fetch from a no-execute 1G page
        q_tr(64'hFFFF_8000_0000_0000, ACC_FETCH, 1'b0);
        q_ent(PTE_NX | 64'h1000 | PTE_P | PTE_RW | PTE_A);
        q_ent(64'h4000_0000 | PTE_P | PTE_RW | PTE_PS);
        // all-ones entry: huge bit at the top level
        q_tr(64'hFFFF_FFFF_FFFF_FFFF, ACC_READ, 1'b1);
        q_ent(64'hFFFF_FFFF_FFFF_FFFF);
        q_tr(64'h0000_1234_5678_9ABC, ACC_READ, 1'b1);
        q_ent(64'h0);                                              // not present
        // misaligned 1G page
        q_tr(64'h0000_0040_0000_0000, ACC_WRITE, 1'b0);
        q_ent(64'h5000 | PTE_P | PTE_US | PTE_A);
        q_ent(64'h4000_2000 | PTE_P | PTE_RW | PTE_US | PTE_PS);
        // supervisor write to a read-only 2M page
        q_tr(64'h0000_0040_0000_0000, ACC_WRITE, 1'b0);
        q_ent(64'h5000 | PTE_P | PTE_US | PTE_A);
        q_ent(64'h6000 | PTE_P | PTE_RW | PTE_US | PTE_A);
        q_ent(64'h0020_0000 | PTE_P | PTE_RW | PTE_US | PTE_PS);
        // user access through a supervisor-only table
        q_tr(64'hFFFF_F000_1234_5678, ACC_READ, 1'b1);
        q_ent(64'h7000 | PTE_P | PTE_RW | PTE_A);
        q_ent(64'h4000_0000 | PTE_P | PTE_RW | PTE_US | PTE_PS | PTE_A);
        // unused access code behaves as a read, 2M page, nothing to write back
        q_tr(64'h0000_0000_0060_1234, 2'd3, 1'b1);
        q_ent(64'h9000 | PTE_P | PTE_RW | PTE_US | PTE_A | PTE_D);
        q_ent(64'hA000 | PTE_P | PTE_RW | PTE_US | PTE_A);
        q_ent(64'h0060_0000 | PTE_P | PTE_RW | PTE_US | PTE_PS | PTE_A);
      end
      while (phase_items < PHASE_ITEMS) queue_walk();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d input transactions under %0d register settings, %0d results checked",
             accepted_cnt, PHASES, results_seen);
    $display("  translations %0d, faults %0d, non-canonical %0d, entry write-backs %0d",
             n_done, n_fault, n_noncanon, n_writeback);
    if (errors == 0) begin
      $display("PASS four_level_page_table_walker");
    end else begin
      $display("FAIL four_level_page_table_walker");
    end
    $finish;
  end

endmodule
